>>> design/ssac_pkg.sv
// shared types and codes for the sectored set-associative cache
package ssac_pkg;

  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_INVAL = 2'd2;
  localparam logic [1:0] ACT_FLUSH = 2'd3;

  localparam logic [1:0] HINT_NONE   = 2'd0;
  localparam logic [1:0] HINT_BYP_L1 = 2'd1;
  localparam logic [1:0] HINT_BYP_ALL = 2'd2;
  localparam logic [1:0] HINT_STREAM = 2'd3;

  localparam int HIST_DEPTH = 5;

  // result of one access
  typedef struct packed {
    logic        served;
    logic [63:0] read_data;
    logic        line_present;
    logic        evicted;
    logic        bypassed;
    logic        streaming;
  } result_t;

  // bytes below n set
  function automatic logic [63:0] byte_mask(input logic [3:0] n);
    logic [63:0] m;
    m = '0;
    for (int k = 0; k < 8; k++) begin
      if (4'(k) < n) m[8*k +: 8] = 8'hff;
    end
    return m;
  endfunction

endpackage

>>> design/ssac_stream_det.sv
// read address history and streaming detector
module ssac_stream_det #(
  parameter int ADDR_BITS  = 32,
  parameter int LINE_BYTES = 128
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic [ADDR_BITS-1:0] addr,
  output logic                 stream_hit
);
  import ssac_pkg::*;

  localparam logic [ADDR_BITS:0] MAX_STEP = (ADDR_BITS+1)'(2 * LINE_BYTES);

  logic [ADDR_BITS-1:0] hist_r [HIST_DEPTH];
  logic [2:0]           fill_r;
  logic [ADDR_BITS-1:0] win [HIST_DEPTH];
  logic [2:0]           steps;
  logic [ADDR_BITS:0]   diff;

  // window including the address being pushed
  always_comb begin
    for (int i = 0; i < HIST_DEPTH - 1; i++) begin
      win[i] = (fill_r >= 3'(HIST_DEPTH)) ? hist_r[i+1] : hist_r[i];
    end
    win[HIST_DEPTH-1] = addr;
    steps = '0;
    diff  = '0;
    for (int i = 1; i < HIST_DEPTH; i++) begin
      diff = {1'b0, win[i]} - {1'b0, win[i-1]};
      if (win[i] > win[i-1] && diff <= MAX_STEP) steps = steps + 3'd1;
    end
    stream_hit = (fill_r >= 3'(HIST_DEPTH - 1)) && (steps >= 3'd3);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (push && fill_r < 3'(HIST_DEPTH)) begin
      fill_r <= fill_r + 3'd1;
    end
  end

  // shift line kept full width; only the newest five count once filled
  always_ff @(posedge clk) begin
    if (push) begin
      if (fill_r >= 3'(HIST_DEPTH)) begin
        for (int i = 0; i < HIST_DEPTH; i++) hist_r[i] <= win[i];
      end else begin
        hist_r[fill_r] <= addr;
      end
    end
  end

endmodule

>>> design/sectored_set_assoc_cache.sv
// top level of the sectored set-associative cache
//
//  channel   ports                               handshake
//  request   in_action in_address in_write_data  start & !busy
//            in_byte_count in_hint
//  result    out_served out_read_data ...        done, one cycle
//  config    cfg_we cfg_adaptive_bypass          cfg_we
//
// reads, writes and invalidates keep busy high through ST_RD, which reads the set's
//   tag/use, valid and sector data memories, and ST_EXEC, which compares and writes back
// done comes in the following idle cycle, which already accepts the next request
// flush clears valid/dirty/written one set per cycle, with busy high until the last set
// after reset a clearing pass over all sets runs with busy high
// the receiver cannot stall; done lasts one cycle
module sectored_set_assoc_cache #(
  parameter int LINE_BYTES   = 128,
  parameter int SECTOR_SIZE  = 8,
  parameter int WAYS         = 4,
  parameter int SETS         = 64,
  parameter int ADDR_BITS    = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_address,
  input  logic [63:0] in_write_data,
  input  logic [3:0]  in_byte_count,
  input  logic [1:0]  in_hint,
  output logic        done,
  output logic        out_served,
  output logic [63:0] out_read_data,
  output logic        out_line_present,
  output logic        out_evicted,
  output logic        out_bypassed,
  output logic        out_streaming,
  input  logic        cfg_we,
  input  logic        cfg_adaptive_bypass
);
  import ssac_pkg::*;

  localparam int SECTORS  = (LINE_BYTES + SECTOR_SIZE - 1) / SECTOR_SIZE;
  localparam int FULL_SEC = LINE_BYTES / SECTOR_SIZE;
  localparam int OFF_W    = (SECTOR_SIZE > 1) ? $clog2(SECTOR_SIZE) : 1;
  localparam int LB_W     = $clog2(LINE_BYTES);
  localparam int SEC_W    = (SECTORS > 1) ? $clog2(SECTORS) : 1;
  localparam int SET_W    = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int TAG_W    = ADDR_BITS - LB_W - ((SETS > 1) ? $clog2(SETS) : 0);
  localparam int ROWS     = SETS * SECTORS;
  localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int VD_W     = WAYS * SECTORS;
  localparam int VD_IW    = (VD_W > 1) ? $clog2(VD_W) : 1;

  // state codes
  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_RD    = 3'd2;
  localparam logic [2:0] ST_EXEC  = 3'd3;
  localparam logic [2:0] ST_FLUSH = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       adapt_r;
  logic [63:0] clk_r;

  // latched request
  logic [1:0]           act_r;
  logic [ADDR_BITS-1:0] addr_r;
  logic [63:0]          wdat_r;
  logic [3:0]           cnt_r;
  logic [1:0]           hint_r;
  logic [SET_W:0]       sweep_r;

  logic [ADDR_BITS-1:0] a_in;
  assign a_in = ADDR_BITS'(in_address);

  // address split
  logic [SET_W-1:0]  set_s;
  logic [TAG_W-1:0]  tag_s;
  logic [LB_W-1:0]   lofs_s;
  logic [SEC_W-1:0]  sec_s;
  logic [OFF_W-1:0]  off_s;
  logic              sec_ok;
  assign lofs_s = LB_W'(addr_r % LINE_BYTES);
  assign set_s  = SET_W'((addr_r / LINE_BYTES) % SETS);
  assign tag_s  = TAG_W'(addr_r / (LINE_BYTES * SETS));
  assign sec_s  = SEC_W'(lofs_s / SECTOR_SIZE);
  assign off_s  = OFF_W'(addr_r % SECTOR_SIZE);
  assign sec_ok = 32'(sec_s) < 32'(FULL_SEC);

  // memories: per set, all ways of tags, use times, valid, dirty and
  // written-since-allocation bits; sector data per set and sector, all ways
  logic [TAG_W-1:0] tag_mem [SETS][WAYS];
  logic [63:0]      use_mem [SETS][WAYS];
  logic [VD_W-1:0]  val_mem [SETS];
  logic [VD_W-1:0]  dty_mem [SETS];
  logic [VD_W-1:0]  wrt_mem [SETS];
  logic [63:0]      dat_mem [ROWS][WAYS];

  logic [TAG_W-1:0] tag_q [WAYS];
  logic [63:0]      use_q [WAYS];
  logic [VD_W-1:0]  val_q, dty_q, wrt_q;
  logic [63:0]      dat_q [WAYS];

  logic rd_en;
  logic [SET_W-1:0] rd_set;
  logic [SEC_W-1:0] rd_sec;
  logic [ROW_W-1:0] sec_row;
  assign rd_en   = (state_r == ST_RD);
  assign rd_set  = set_s;
  assign rd_sec  = sec_s;
  assign sec_row = ROW_W'(32'(rd_set) * SECTORS + 32'(rd_sec));

  always_ff @(posedge clk) begin
    if (rd_en) begin
      val_q <= val_mem[rd_set];
      dty_q <= dty_mem[rd_set];
      wrt_q <= wrt_mem[rd_set];
      for (int w = 0; w < WAYS; w++) begin
        tag_q[w] <= tag_mem[rd_set][w];
        use_q[w] <= use_mem[rd_set][w];
        dat_q[w] <= dat_mem[sec_row][w];
      end
    end
  end

  // lookup on registered read data
  logic [WAYS-1:0] live, hitv;
  logic            hit;
  logic [WAY_W-1:0] hit_w, free_w, lru_w, vict_w, way_u;
  logic            any_free;
  always_comb begin
    hit = 1'b0; hit_w = '0; any_free = 1'b0; free_w = '0; lru_w = '0;
    for (int w = 0; w < WAYS; w++) begin
      live[w] = |val_q[w*SECTORS +: SECTORS];
      hitv[w] = live[w] && (tag_q[w] == tag_s);
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hitv[w]) begin hit = 1'b1; hit_w = WAY_W'(w); end
      if (!live[w]) begin any_free = 1'b1; free_w = WAY_W'(w); end
    end
    for (int w = 1; w < WAYS; w++) begin
      if (use_q[w] < use_q[lru_w]) lru_w = WAY_W'(w);
    end
    vict_w = any_free ? free_w : lru_w;
  end

  // bit positions in the per-set valid/dirty/written words
  logic [VD_IW-1:0] hit_bit, way_bit, way_base;
  assign hit_bit  = VD_IW'(32'(hit_w) * SECTORS + 32'(sec_s));
  assign way_bit  = VD_IW'(32'(way_u) * SECTORS + 32'(sec_s));
  assign way_base = VD_IW'(32'(way_u) * SECTORS);

  // streaming detector sees the read address as it enters
  logic det_push, det_hit;
  assign det_push = (state_r == ST_RD) && (act_r == ACT_READ);
  ssac_stream_det #(.ADDR_BITS(ADDR_BITS), .LINE_BYTES(LINE_BYTES)) u_det (
    .clk(clk), .rst_n(rst_n), .push(det_push), .addr(addr_r), .stream_hit(det_hit)
  );
  logic det_r;
  always_ff @(posedge clk) begin
    if (det_push) det_r <= det_hit;
  end

  // execute stage decisions
  logic [1:0]  eff_hint;
  logic [3:0]  copy;
  logic [63:0] m, old_d, new_d;
  logic [5:0]  shamt;
  result_t     res;
  logic        do_alloc, do_wr, do_touch, do_inv;
  logic [63:0] clk_nxt;
  assign clk_nxt = clk_r + 64'd1;

  always_comb begin
    copy = 4'(SECTOR_SIZE) - 4'(off_s);
    if (cnt_r < copy) copy = cnt_r;
    shamt = {off_s, 3'b000} & 6'h38;
    m = byte_mask(copy) << shamt;
    eff_hint = hint_r;
    if (act_r == ACT_READ && adapt_r && hint_r == HINT_NONE && det_r) eff_hint = HINT_STREAM;
    res = '0; do_alloc = 1'b0; do_wr = 1'b0; do_touch = 1'b0; do_inv = 1'b0;
    way_u = hit_w;
    old_d = dat_q[hit_w];
    new_d = '0;
    case (act_r)
      ACT_READ: begin
        if (eff_hint == HINT_BYP_L1 || eff_hint == HINT_BYP_ALL) begin
          res.bypassed = 1'b1;
        end else begin
          res.streaming = (eff_hint == HINT_STREAM);
          if (hit) begin
            res.line_present = 1'b1;
            do_touch = 1'b1;
            if (sec_ok && val_q[hit_bit]) begin
              res.served = 1'b1;
              res.read_data = (old_d >> shamt) & byte_mask(copy);
            end
          end
        end
      end
      ACT_WRITE: begin
        if (hint_r == HINT_BYP_ALL) begin
          res.bypassed = 1'b1;
        end else begin
          res.streaming = (hint_r == HINT_STREAM);
          res.line_present = hit;
          if (hit || hint_r != HINT_STREAM) begin
            res.served = 1'b1;
            if (!hit) begin
              do_alloc = 1'b1;
              way_u = vict_w;
              old_d = '0;
              res.evicted = !any_free;
            end else if (!wrt_q[hit_bit]) begin
              // sector untouched since allocation holds zero
              old_d = '0;
            end
            do_wr = sec_ok;
            do_touch = sec_ok || !hit;
            new_d = (old_d & ~m) | ((wdat_r << shamt) & m);
          end
        end
      end
      ACT_INVAL: begin
        res.line_present = hit;
        do_inv = hit && sec_ok;
      end
      default: ;
    endcase
  end

  // write back
  logic ex;
  assign ex = (state_r == ST_EXEC);
  logic [VD_W-1:0] val_w, dty_w, wrt_w;
  always_comb begin
    val_w = val_q; dty_w = dty_q; wrt_w = wrt_q;
    if (do_alloc) begin
      val_w[way_base +: SECTORS] = '0;
      dty_w[way_base +: SECTORS] = '0;
      wrt_w[way_base +: SECTORS] = '0;
    end
    if (do_wr) begin
      val_w[way_bit] = 1'b1;
      dty_w[way_bit] = 1'b1;
      wrt_w[way_bit] = 1'b1;
    end
    if (do_inv) begin
      val_w[hit_bit] = 1'b0;
      dty_w[hit_bit] = 1'b0;
    end
  end

  // sectors of a fresh allocation read as zero until written, through the
  // written bits; an invalidated sector keeps its written bit, so a write merges its old data
  always_ff @(posedge clk) begin
    if (state_r == ST_CLEAR || state_r == ST_FLUSH) begin
      val_mem[SET_W'(sweep_r)] <= '0;
      dty_mem[SET_W'(sweep_r)] <= '0;
      wrt_mem[SET_W'(sweep_r)] <= '0;
    end else if (ex) begin
      val_mem[set_s] <= val_w;
      dty_mem[set_s] <= dty_w;
      wrt_mem[set_s] <= wrt_w;
      if (do_alloc) tag_mem[set_s][way_u] <= tag_s;
      if (do_touch) use_mem[set_s][way_u] <= clk_nxt;
      if (do_wr) dat_mem[sec_row][way_u] <= new_d;
    end
  end

  // control
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (32'(sweep_r) == SETS - 1) state_nxt = ST_IDLE;
      ST_IDLE:  if (start) state_nxt = (in_action == ACT_FLUSH) ? ST_FLUSH : ST_RD;
      ST_RD:    state_nxt = ST_EXEC;
      ST_EXEC:  state_nxt = ST_IDLE;
      ST_FLUSH: if (32'(sweep_r) == SETS) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      sweep_r <= '0;
      adapt_r <= 1'b0;
      clk_r   <= '0;
      done    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) adapt_r <= cfg_adaptive_bypass;
      if (state_r == ST_IDLE) sweep_r <= '0;
      else if (state_r == ST_CLEAR || state_r == ST_FLUSH) sweep_r <= sweep_r + 1'b1;
      if (ex && (act_r == ACT_READ || act_r == ACT_WRITE)) clk_r <= clk_nxt;
      done <= ex || (state_r == ST_FLUSH && 32'(sweep_r) == SETS);
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      act_r  <= in_action;
      addr_r <= a_in;
      wdat_r <= in_write_data;
      cnt_r  <= in_byte_count;
      hint_r <= in_hint;
    end
    if (ex) begin
      out_served       <= res.served;
      out_read_data    <= res.read_data;
      out_line_present <= res.line_present;
      out_evicted      <= res.evicted;
      out_bypassed     <= res.bypassed;
      out_streaming    <= res.streaming;
    end else if (state_r == ST_FLUSH) begin
      out_served <= 1'b0; out_read_data <= '0; out_line_present <= 1'b0;
      out_evicted <= 1'b0; out_bypassed <= 1'b0; out_streaming <= 1'b0;
    end
  end

  assign busy = (state_r != ST_IDLE);

  a_one_way_hit: assert property (@(posedge clk) disable iff (!rst_n)
    ex |-> $onehot0(hitv)) else $error("tag hit in two ways");
  a_exec_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    ex |-> $past(state_r) == ST_RD) else $error("execute without read");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> !done) else $error("done longer than one cycle");

endmodule
